@@ rtl/zone_owner_radix_map_core_assert.svh @@
// Assertion macros shared by the zone owner map RTL.
`ifndef ZONE_OWNER_RADIX_MAP_CORE_ASSERT_SVH
`define ZONE_OWNER_RADIX_MAP_CORE_ASSERT_SVH

`ifndef SYNTH

`define ZORM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("zone owner map: same-cycle check failed");

`define ZORM_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("zone owner map: next-cycle check failed");

`else

`define ZORM_ASSERT_IMP(label, ante, cons)

`define ZORM_ASSERT_NXT(label, ante, cons)

`endif

`endif

@@ rtl/zorm_pkg.sv @@
// Shared types and constants for the zone owner map.
package zorm_pkg;

  localparam int ZONE_INDEX_W = 26;
  localparam int PORT_OWNER_W = 16;
  localparam int Y_LSB        = 16;
  localparam int REFCNT_W     = 9;
  localparam int LEAF_CNT_W   = 13;

  typedef enum logic [1:0] {
    FUNC_READ  = 2'd0,
    FUNC_REMAP = 2'd1,
    FUNC_UNMAP = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic                present;
    logic [REFCNT_W-1:0] refcnt;
  } blk_entry_t;

endpackage

@@ rtl/zone_owner_radix_map_core.sv @@
// Each word is read from the block descriptor memory and the owner row memory when it is
// taken, then updated and written back to both; the next word is taken only after that,
// while the result side keeps up. The owner memory holds one row of 2^LEAF_BITS entries
// per leaf Y coordinate of a block; after reset a clearing pass zeroes it one row a cycle,
// over all 2^(2*(MID_BITS+TOP_BITS)+LEAF_BITS) rows (65536 at the defaults), and no
// word is accepted until it ends. A finished result waits in the output register and stalls
// the next word only while it is not taken.
module zone_owner_radix_map_core
  import zorm_pkg::*;
#(
  parameter int LEAF_BITS   = 4,
  parameter int MID_BITS    = 3,
  parameter int TOP_BITS    = 3,
  parameter int OWNER_WIDTH = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    req_valid,
  output logic                    req_stall,
  input  logic [1:0]              func,
  input  logic [ZONE_INDEX_W-1:0] zone_index,
  input  logic [PORT_OWNER_W-1:0] expected_owner,
  input  logic [PORT_OWNER_W-1:0] new_owner,
  output logic                    rsp_valid,
  input  logic                    rsp_stall,
  output logic                    ok,
  output logic [PORT_OWNER_W-1:0] owner,
  output logic [LEAF_CNT_W-1:0]   leaves_in_use
);

  localparam int COORD_BITS  = LEAF_BITS + MID_BITS + TOP_BITS;
  localparam int BLOCK_BITS  = 2 * (MID_BITS + TOP_BITS);
  localparam int ROW_AW      = BLOCK_BITS + LEAF_BITS;
  localparam int ROW_ENTRIES = 1 << LEAF_BITS;
  localparam int ROW_W       = ROW_ENTRIES * OWNER_WIDTH;
  localparam int NUM_ROWS    = 1 << ROW_AW;
  localparam int NUM_BLOCKS  = 1 << BLOCK_BITS;

  state_t state, state_next;
  logic   req_accept, clear_active, exec_done;

  logic [ROW_AW-1:0] clr_addr;

  // Index split into block and row addresses.
  logic [31:0]            zi_ext;
  logic [COORD_BITS-1:0]  x_crd, y_crd;
  logic [BLOCK_BITS-1:0]  in_block;
  logic [ROW_AW-1:0]      in_row;

  // Word under work.
  logic [1:0]             q_func;
  logic [ROW_AW-1:0]      q_row;
  logic [LEAF_BITS-1:0]   q_xleaf;
  logic [OWNER_WIDTH-1:0] q_exp, q_new;
  logic [BLOCK_BITS-1:0]  q_block;

  // Memories.
  logic [ROW_W-1:0] row_mem [NUM_ROWS];
  logic [ROW_W-1:0] row_rdata, row_upd, row_wdata;
  logic [ROW_AW-1:0] row_waddr;
  logic              row_we;

  blk_entry_t             blk_mem [NUM_BLOCKS];
  blk_entry_t             blk_rd, blk_new, blk_wdata;
  logic [BLOCK_BITS-1:0]  blk_waddr;
  logic                   blk_we;

  // Update logic.
  logic [OWNER_WIDTH-1:0] entry, prior, entry_new;
  logic [REFCNT_W-1:0]    refc_base, refc_dec;
  logic [LEAF_CNT_W-1:0]  leaf_count, leaf_count_next;
  logic                   ok_next, row_we_x, blk_we_x;
  logic [31:0]            prior_ext;

  assign zi_ext   = {{(32 - ZONE_INDEX_W){1'b0}}, zone_index};
  assign x_crd    = zi_ext[COORD_BITS-1:0];
  assign y_crd    = zi_ext[Y_LSB +: COORD_BITS];
  assign in_block = {y_crd[LEAF_BITS + MID_BITS +: TOP_BITS],
                     x_crd[LEAF_BITS + MID_BITS +: TOP_BITS],
                     y_crd[LEAF_BITS +: MID_BITS],
                     x_crd[LEAF_BITS +: MID_BITS]};
  assign in_row   = {in_block, y_crd[LEAF_BITS-1:0]};
  assign q_block  = q_row[ROW_AW-1 -: BLOCK_BITS];

  // Control.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (clear_active) begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (&clr_addr) state_next = ST_IDLE;
      ST_IDLE:  if (req_valid) state_next = ST_EXEC;
      ST_EXEC:  if (!rsp_valid || !rsp_stall) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    req_stall    = 1'b1;
    clear_active = 1'b0;
    exec_done    = 1'b0;
    unique case (state)
      ST_CLEAR: clear_active = 1'b1;
      ST_IDLE:  req_stall = 1'b0;
      ST_EXEC:  exec_done = !rsp_valid || !rsp_stall;
      default:  req_stall = 1'b1;
    endcase
  end

  assign req_accept = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (req_accept) begin
      q_func  <= func;
      q_row   <= in_row;
      q_xleaf <= x_crd[LEAF_BITS-1:0];
      q_exp   <= OWNER_WIDTH'({16'b0, expected_owner});
      q_new   <= OWNER_WIDTH'({16'b0, new_owner});
    end
  end

  // Owner row memory and block descriptor memory, registered reads.
  always_ff @(posedge clk) begin
    if (row_we) begin
      row_mem[row_waddr] <= row_wdata;
    end
    if (req_accept) begin
      row_rdata <= row_mem[in_row];
    end
  end

  always_ff @(posedge clk) begin
    if (blk_we) begin
      blk_mem[blk_waddr] <= blk_wdata;
    end
    if (req_accept) begin
      blk_rd <= blk_mem[in_block];
    end
  end

  // Entries of a block that is not in use are always zero: the clearing pass
  // zeroes them, and a block is freed only once its last entry is unmapped.
  always_comb begin
    entry     = row_rdata[q_xleaf * OWNER_WIDTH +: OWNER_WIDTH];
    prior     = blk_rd.present ? entry : '0;
    refc_base = blk_rd.present ? blk_rd.refcnt : '0;
    refc_dec  = blk_rd.refcnt - 1'b1;

    ok_next         = 1'b0;
    row_we_x        = 1'b0;
    blk_we_x        = 1'b0;
    entry_new       = q_new;
    blk_new         = blk_rd;
    leaf_count_next = leaf_count;

    unique case (q_func)
      FUNC_REMAP: begin
        if (q_new != '0) begin
          blk_we_x        = 1'b1;
          blk_new.present = 1'b1;
          blk_new.refcnt  = refc_base;
          if (!blk_rd.present) begin
            leaf_count_next = leaf_count + 1'b1;
          end
          if (prior == q_exp) begin
            row_we_x = 1'b1;
            ok_next  = 1'b1;
            if (q_exp == '0) begin
              blk_new.refcnt = refc_base + 1'b1;
            end
          end
        end
      end
      FUNC_UNMAP: begin
        if (blk_rd.present && prior != '0) begin
          row_we_x       = 1'b1;
          blk_we_x       = 1'b1;
          entry_new      = '0;
          ok_next        = 1'b1;
          blk_new.refcnt = refc_dec;
          if (refc_dec == '0) begin
            blk_new.present = 1'b0;
            leaf_count_next = leaf_count - 1'b1;
          end
        end
      end
      default: ok_next = (prior != '0);
    endcase

    row_upd = row_rdata;
    row_upd[q_xleaf * OWNER_WIDTH +: OWNER_WIDTH] = entry_new;
  end

  assign row_we    = clear_active || (exec_done && row_we_x);
  assign row_waddr = clear_active ? clr_addr : q_row;
  assign row_wdata = clear_active ? '0 : row_upd;

  assign blk_we    = clear_active || (exec_done && blk_we_x);
  assign blk_waddr = clear_active ? clr_addr[ROW_AW-1 -: BLOCK_BITS] : q_block;
  assign blk_wdata = clear_active ? '0 : blk_new;

  assign prior_ext = 32'(prior);

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid  <= 1'b0;
      leaf_count <= '0;
    end else begin
      if (exec_done) begin
        rsp_valid  <= 1'b1;
        leaf_count <= leaf_count_next;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exec_done) begin
      ok    <= ok_next;
      owner <= prior_ext[PORT_OWNER_W-1:0];
    end
  end

  assign leaves_in_use = leaf_count;

`include "zone_owner_radix_map_core_assert.svh"

  `ZORM_ASSERT_NXT(a_accept_exec, req_accept, state == ST_EXEC)
  `ZORM_ASSERT_NXT(a_count_stable, !exec_done, $stable(leaf_count))
  `ZORM_ASSERT_IMP(a_unmap_absent, exec_done && !blk_rd.present && q_func == FUNC_UNMAP, !ok_next)
  `ZORM_ASSERT_NXT(a_done_shows, exec_done, rsp_valid)

endmodule
